[hw/rtl/tkms_pkg.sv]
// Shared types and constants for the top-k min-heap selector.
// No dependencies; imported by tkms_cell, top_k_min_heap_selector, tkms_checker and tb.
`default_nettype none

package tkms_pkg;

	localparam int MAX_KEEP    = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int KEEP_W      = 5;
	localparam int FILL_W      = $clog2(MAX_KEEP + 1);
	localparam int IDX_W       = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

	// One input transaction
	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] sample_value;
		logic                          stream_end;
	} tkms_in_t;

	// One result transaction
	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] kept_value;
		logic                          run_last;
	} tkms_out_t;

	// Link from one cell to the next one down the chain
	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] val;
		logic                          keep;
	} link_t;

	// Clamp the programmed count to 1..MAX_KEEP
	function automatic logic [FILL_W-1:0] eff_keep(input logic [KEEP_W-1:0] kc);
		logic [FILL_W-1:0] r;
		if (kc == '0) begin
			r = FILL_W'(1);
		end else if (32'(kc) > MAX_KEEP) begin
			r = FILL_W'(MAX_KEEP);
		end else begin
			r = FILL_W'(kc);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/tkms_cell.sv]
// One slot of the sorted keep chain (largest value at the head).
// Depends on tkms_pkg for link_t and VALUE_WIDTH.
`default_nettype none

module tkms_cell (
	input  wire                                  clk,
	input  wire                                  ins_en,
	input  wire                                  valid,
	input  wire signed [tkms_pkg::VALUE_WIDTH-1:0] new_val,
	input  tkms_pkg::link_t                      up,
	output tkms_pkg::link_t                      down
);
	import tkms_pkg::*;

	logic signed [VALUE_WIDTH-1:0] val_q;
	logic                          keep;

	// slot holds when it is valid and not below the incoming value
	assign keep = valid && !(val_q < new_val);

	// insertion: hold, take the new value at the boundary, or shift down
	always_ff @(posedge clk) begin
		if (ins_en && !keep) begin
			val_q <= up.keep ? new_val : up.val;
		end
	end

	assign down.val  = val_q;
	assign down.keep = keep;

endmodule

`default_nettype wire

[hw/rtl/top_k_min_heap_selector.sv]
// Top level of the top-k selector: chain of sorted cells plus drain control.
// Depends on tkms_pkg and tkms_cell.
`default_nettype none

// Keeps the keep_count largest signed values of a stream and, on the value
// marked stream_end, emits them in ascending order, flagging the last one.
// One value is accepted per cycle while busy is low: it is broadcast to a row of
// MAX_KEEP cells that compare in parallel and shift the smaller entries one cell
// down. A value with stream_end then starts a drain of the kept values (1 to
// MAX_KEEP), read out from the chain's tail; busy is high during that drain
// and start is ignored. Results appear one per cycle on result with
// result_strobe for a single cycle and cannot be held off. keep_count must be
// written only while busy is low and no result is pending; the block itself
// does not enforce this. 0 acts as 1 and values above MAX_KEEP act as MAX_KEEP.
module top_k_min_heap_selector (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	output logic                          busy,
	input  tkms_pkg::tkms_in_t            item,
	output logic                          result_strobe,
	output tkms_pkg::tkms_out_t           result,
	input  wire                           cfg_wen,
	input  wire  [tkms_pkg::KEEP_W-1:0]   cfg_wdata
);
	import tkms_pkg::*;

	logic [KEEP_W-1:0] keep_count_q;
	logic [FILL_W-1:0] fill_q;
	logic              drain_q;
	logic              strobe_q;
	tkms_out_t         result_q;

	logic              accept;
	logic [FILL_W:0]   fill_inc;
	logic [FILL_W-1:0] keep_eff;
	logic [FILL_W-1:0] fill_new;
	logic [FILL_W-1:0] rd_pos;
	link_t             chain [MAX_KEEP+1];

	assign accept = start && !drain_q;
	assign busy   = drain_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= KEEP_W'(1);
		end else if (cfg_wen) begin
			keep_count_q <= cfg_wdata;
		end
	end

	// cell row; the head link always says "insert here"
	assign chain[0].val  = item.sample_value;
	assign chain[0].keep = 1'b1;

	for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
		tkms_cell u_cell (
			.clk     (clk),
			.ins_en  (accept),
			.valid   (32'(i) < 32'(fill_q)),
			.new_val (item.sample_value),
			.up      (chain[i]),
			.down    (chain[i+1])
		);
	end

	// fill after insert, truncated to the effective keep count
	assign keep_eff = eff_keep(keep_count_q);
	assign fill_inc = {1'b0, fill_q} + (FILL_W+1)'(1);
	assign fill_new = (fill_inc > {1'b0, keep_eff}) ? keep_eff : fill_inc[FILL_W-1:0];

	// drain position; the smallest kept entry is the output link of cell fill_q-1
	assign rd_pos = fill_q - FILL_W'(1);

	// fill and drain control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			drain_q  <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= drain_q;
			if (drain_q) begin
				fill_q <= rd_pos;
				if (fill_q == FILL_W'(1)) begin
					drain_q <= 1'b0;
				end
			end else if (accept) begin
				fill_q  <= fill_new;
				drain_q <= item.stream_end;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (drain_q) begin
			result_q.kept_value <= chain[fill_q].val;
			result_q.run_last   <= (fill_q == FILL_W'(1));
		end
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

endmodule

`default_nettype wire

[sim/tkms_checker.sv]
// Scoreboard for the top-k min-heap selector: watches the input, result and
// keep-count write ports, predicts each drain and compares it.
// Depends on tkms_pkg.
module tkms_checker
	import tkms_pkg::*;
(
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	input  wire               busy,
	input  tkms_in_t          item,
	input  wire               cfg_wen,
	input  wire  [KEEP_W-1:0] cfg_wdata,
	input  wire               result_strobe,
	input  tkms_out_t         result,
	output int                fail_count,
	output int                pending
);

	// Kept values, always sorted ascending; front is the heap minimum
	logic signed [VALUE_WIDTH-1:0] kept_sorted[$];
	// Drain results still owed by the block, oldest first
	tkms_out_t                     expected_drain[$];
	logic [KEEP_W-1:0]             keep_reg;
	int                            mismatch_total = 0;

	task automatic report_mismatch(input string msg);
		$display("%0t ERROR: %s", $time, msg);
		mismatch_total++;
	endtask

	// Zero keeps one value; anything past the store size saturates
	function automatic int clamp_keep(input logic [KEEP_W-1:0] k);
		if (k == '0) return 1;
		if (int'(k) > MAX_KEEP) return MAX_KEEP;
		return int'(k);
	endfunction

	// Insert one sample, trim to the kept count, and queue the drain on stream end
	task automatic predict_sample(input tkms_in_t t);
		int        pos;
		int        limit;
		tkms_out_t r;
		pos = 0;
		limit = clamp_keep(keep_reg);
		while (pos < kept_sorted.size() && kept_sorted[pos] < t.sample_value) pos++;
		kept_sorted.insert(pos, t.sample_value);
		// a lowered count can evict several minima at once
		while (kept_sorted.size() > limit) void'(kept_sorted.pop_front());
		if (t.stream_end) begin
			foreach (kept_sorted[i]) begin
				r.kept_value = kept_sorted[i];
				r.run_last = (i == kept_sorted.size() - 1);
				expected_drain.push_back(r);
			end
			kept_sorted.delete();
		end
	endtask

	task automatic check_result(input tkms_out_t got);
		tkms_out_t want;
		if (expected_drain.size() == 0) begin
			report_mismatch($sformatf("unexpected result value %0d last %0b",
				got.kept_value, got.run_last));
		end else begin
			want = expected_drain.pop_front();
			if (got.kept_value !== want.kept_value)
				report_mismatch($sformatf("kept_value %0d, expected %0d",
					got.kept_value, want.kept_value));
			if (got.run_last !== want.run_last)
				report_mismatch($sformatf("run_last %0b on value %0d, expected %0b",
					got.run_last, want.kept_value, want.run_last));
		end
	endtask

	// Sample every port at the clock edge; inputs use the count held before a write
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_sorted.delete();
			expected_drain.delete();
			keep_reg = KEEP_W'(1);
			pending <= 0;
			fail_count <= mismatch_total;
		end else begin
			if (start === 1'b1 && busy === 1'b0) predict_sample(item);
			if (cfg_wen === 1'b1) keep_reg = cfg_wdata;
			if (result_strobe === 1'b1) check_result(result);
			pending <= expected_drain.size();
			fail_count <= mismatch_total;
		end
	end

endmodule

[sim/tb.sv]
// Testbench top for the top-k min-heap selector: clock, reset, directed and
// random streams with keep-count changes, and the final verdict.
// Depends on tkms_pkg, top_k_min_heap_selector and tkms_checker.
module tb;
	import tkms_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_ITEMS = 185;
	localparam int CALM_ITEMS   = 40;

	localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	tkms_in_t          item = '0;
	logic              cfg_wen = 1'b0;
	logic [KEEP_W-1:0] cfg_wdata = '0;
	logic              busy;
	logic              result_strobe;
	tkms_out_t         result;
	int                fails;
	int                pend;
	bit                gaps_on = 1'b1;
	int                sent = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	top_k_min_heap_selector u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_strobe(result_strobe),
		.result       (result),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata)
	);

	tkms_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.result_strobe(result_strobe),
		.result       (result),
		.fail_count   (fails),
		.pending      (pend)
	);

	// One input transaction, optionally after an idle burst; start stays high
	task automatic send_sample(input logic signed [VALUE_WIDTH-1:0] v, input logic last);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		start <= 1'b1;
		item <= '{sample_value: v, stream_end: last};
		do @(posedge clk); while (busy !== 1'b0);
		sent++;
	endtask

	// Wait for the drain to finish and the last insert to settle
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pend != 0 || busy !== 1'b0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_keep(input logic [KEEP_W-1:0] k);
		settle();
		cfg_wen <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Corners, a narrow band that yields many equal values, and full-range noise
	function automatic logic signed [VALUE_WIDTH-1:0] pick_sample();
		logic signed [VALUE_WIDTH-1:0] v;
		case ($urandom_range(0, 5))
			0: begin
				v = $urandom_range(0, 1) ? VAL_MIN + $urandom_range(0, 3)
					: VAL_MAX - $urandom_range(0, 3);
			end
			1, 2: begin
				v = $urandom_range(0, 16) - 8;
			end
			default: begin
				v = $urandom();
			end
		endcase
		return v;
	endfunction

	function automatic logic [KEEP_W-1:0] pick_keep();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return KEEP_W'(1);
			2: return KEEP_W'(MAX_KEEP);
			3: return KEEP_W'($urandom_range(MAX_KEEP + 1, 31));
			default: return KEEP_W'($urandom_range(1, MAX_KEEP));
		endcase
	endfunction

	// One stream, occasionally changing the kept count partway through
	task automatic run_stream(input int len);
		for (int i = 0; i < len; i++) begin
			if (i > 0 && i < len - 1 && $urandom_range(0, 9) == 0) set_keep(pick_keep());
			send_sample(pick_sample(), i == len - 1);
		end
	endtask

	initial begin
		int len;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// count from reset keeps only the largest
		send_sample(5, 1'b0);
		send_sample(-3, 1'b0);
		send_sample(7, 1'b1);

		// zero count acts as one
		set_keep('0);
		send_sample(VAL_MIN, 1'b0);
		send_sample(VAL_MAX, 1'b1);

		// oversized count saturates; extremes, sign boundary and equal values
		set_keep(KEEP_W'(31));
		send_sample(VAL_MIN, 1'b0);
		send_sample(VAL_MAX, 1'b0);
		send_sample(0, 1'b0);
		send_sample(-1, 1'b0);
		send_sample(1, 1'b0);
		send_sample(-1, 1'b0);
		send_sample(VAL_MIN, 1'b0);
		send_sample(42, 1'b0);
		send_sample(42, 1'b0);
		send_sample(-100, 1'b1);

		// full count, single-value stream
		set_keep(KEEP_W'(MAX_KEEP));
		send_sample(9, 1'b1);

		// count lowered in the middle of a stream
		set_keep(KEEP_W'(5));
		send_sample(10, 1'b0);
		send_sample(-20, 1'b0);
		send_sample(30, 1'b0);
		send_sample(-40, 1'b0);
		send_sample(50, 1'b0);
		send_sample(-60, 1'b0);
		set_keep(KEEP_W'(2));
		send_sample(0, 1'b1);

		// random streams; the tail runs with no idle gaps
		len = sent + RANDOM_ITEMS;
		while (sent < len) begin
			gaps_on = (sent < len - CALM_ITEMS) && $urandom_range(0, 2) != 0;
			set_keep(pick_keep());
			run_stream($urandom_range(0, 5) == 0 ? $urandom_range(17, 40)
				: $urandom_range(1, 20));
		end

		settle();
		repeat (20) @(posedge clk);
		if (fails == 0 && pend == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * 20);
		$display("Verification failed");
		$finish;
	end

endmodule
